// ===== rtl/core/hrir_bwl_pkg.sv =====
package hrir_bwl_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_AZIMUTHS         = 64;
  localparam int DEF_MAX_ELEVATIONS       = 64;
  localparam int DEF_WEIGHT_FRACTION_BITS = 16;

  // Angles are signed degrees with eight fraction bits, held wide enough for mirrored values.
  localparam int ANG_FRAC = 8;
  localparam int ANG_W    = 20;

  localparam logic signed [ANG_W-1:0] MIRROR_AZ_LOW2  = -ANG_W'(46080);
  localparam logic signed [ANG_W-1:0] MIRROR_AZ_HIGH2 = ANG_W'(46080);
  localparam logic signed [ANG_W-1:0] MIRROR_EL2      = ANG_W'(92160);

  localparam int               OUT_W   = 17;
  localparam logic [OUT_W-1:0] OUT_ONE = 17'h10000;
  localparam int               INDEX_W = 12;

  localparam int REG_NUM_AZIMUTHS   = 0;
  localparam int REG_NUM_ELEVATIONS = 1;

  typedef enum logic [1:0] {
    CMD_LOAD_AZ   = 2'd0,
    CMD_LOAD_EL   = 2'd1,
    CMD_BILINEAR  = 2'd2,
    CMD_NEAREST   = 2'd3
  } cmd_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_AZ   = 7'b0000010,
    S_EL_A = 7'b0000100,
    S_EL_B = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

endpackage

// ===== rtl/core/hrir_bilinear_weight_lookup_top.sv =====
// Bilinear weight lookup on a sorted grid of head-related measurements.
// Input channel (in_valid/in_stall) carries one transaction per command. Load
// commands write an azimuth or an elevation table entry in the cycle they are
// accepted and produce no result. Query commands produce exactly one result
// transaction on the output channel (out_valid/out_stall) carrying four indices
// and four Q1.16 weights; a nearest query fills only index_a and weight_a.
// The configuration port (cfg_we/cfg_index/cfg_data) sets the ring and
// elevation counts and must only be written while the block is idle.
// A bilinear query walks three table searches through one registered memory read per
// cycle, up to three restoring divisions and eight passes through one shared multiplier;
// a nearest query walks the azimuth search and one elevation search, skips the divisions
// and computes only its index in the multiplier. The block takes no new transaction
// while a query is in flight, but a finished result waits in the output register so
// the next transaction is accepted even while the receiver stalls. A second query
// completed under a stall waits in its final state until the output frees.
// Reset clears the sequencer, the output valid and sets both counts to one;
// the tables themselves are not cleared.
module hrir_bilinear_weight_lookup_top
  import hrir_bwl_pkg::*;
#(
  parameter int MAX_AZIMUTHS         = DEF_MAX_AZIMUTHS,
  parameter int MAX_ELEVATIONS       = DEF_MAX_ELEVATIONS,
  parameter int WEIGHT_FRACTION_BITS = DEF_WEIGHT_FRACTION_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [5:0]          ring,
  input  logic [5:0]          slot,
  input  logic signed [9:0]   table_degrees,
  input  logic signed [15:0]  azimuth_deg,
  input  logic signed [17:0]  elevation_deg,
  input  logic                z_positive,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [11:0]         index_a,
  output logic [11:0]         index_b,
  output logic [11:0]         index_c,
  output logic [11:0]         index_d,
  output logic [16:0]         weight_a,
  output logic [16:0]         weight_b,
  output logic [16:0]         weight_c,
  output logic [16:0]         weight_d
);

  localparam int AZW   = $clog2(MAX_AZIMUTHS);
  localparam int MAXN  = (MAX_AZIMUTHS > MAX_ELEVATIONS) ? MAX_AZIMUTHS : MAX_ELEVATIONS;
  localparam int CNTW  = $clog2(MAXN + 1);
  localparam int ELD   = MAX_AZIMUTHS * MAX_ELEVATIONS;
  localparam int ELAW  = $clog2(ELD);
  localparam int F     = WEIGHT_FRACTION_BITS;
  localparam int WW    = F + 1;
  localparam int PW    = 2 * WW;
  localparam int SH    = 2 * F - 16;
  localparam int SW    = ANG_W + 2;
  localparam int NW    = SW - 1;
  localparam int DVW   = NW + F + 1;
  localparam int DCW   = $clog2(WW + 1);
  localparam logic [WW-1:0] W_ONE = WW'(1) << F;
  localparam logic [PW-1:0] HALF  = (SH == 0) ? '0 : (PW'(1) << ((SH > 0) ? SH - 1 : 0));

  // Configuration registers and their clamped counts.
  logic [6:0]      num_azimuths;
  logic [6:0]      num_elevations;
  logic [CNTW-1:0] na;
  logic [CNTW-1:0] ne;

  always_comb begin
    if (num_azimuths == '0) na = CNTW'(1);
    else if (int'(num_azimuths) > MAX_AZIMUTHS) na = CNTW'(MAX_AZIMUTHS);
    else na = CNTW'(num_azimuths);
    if (num_elevations == '0) ne = CNTW'(1);
    else if (int'(num_elevations) > MAX_ELEVATIONS) ne = CNTW'(MAX_ELEVATIONS);
    else ne = CNTW'(num_elevations);
  end

  state_t state;
  logic   in_acc;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Table memories with registered reads.
  logic signed [8:0] az_mem [MAX_AZIMUTHS];
  logic signed [9:0] el_mem [ELD];
  logic signed [8:0] az_q;
  logic signed [9:0] el_q;
  logic [CNTW-1:0]   scan;
  logic [CNTW-1:0]   srch_row;
  logic [ELAW-1:0]   el_raddr;
  logic [ELAW-1:0]   el_waddr;

  assign el_raddr = ELAW'(int'(srch_row) * MAX_ELEVATIONS + int'(scan));
  assign el_waddr = ELAW'(int'(ring) * MAX_ELEVATIONS + int'(slot));

  always_ff @(posedge clk) begin
    if (in_acc && cmd == CMD_LOAD_AZ && int'(ring) < MAX_AZIMUTHS) begin
      az_mem[AZW'(ring)] <= table_degrees[8:0];
    end
    az_q <= az_mem[AZW'(scan)];
  end

  always_ff @(posedge clk) begin
    if (in_acc && cmd == CMD_LOAD_EL && int'(ring) < MAX_AZIMUTHS &&
        int'(slot) < MAX_ELEVATIONS) begin
      el_mem[el_waddr] <= table_degrees;
    end
    el_q <= el_mem[el_raddr];
  end

  // Shared upper-bound search: one entry compared per cycle.
  logic                    rd_valid;
  logic [CNTW-1:0]         rd_idx;
  logic [CNTW-1:0]         srch_n;
  logic signed [ANG_W-1:0] srch_needle;
  logic signed [ANG_W-1:0] prev_ang;
  logic signed [9:0]       ent;
  logic signed [ANG_W-1:0] ent_ang;
  logic                    hit;
  logic                    s_done;
  logic [CNTW-1:0]         u;
  logic [CNTW-1:0]         s_lo;
  logic [CNTW-1:0]         s_hi;
  logic signed [ANG_W-1:0] s_lo_ang;

  always_comb begin
    ent      = (state == S_AZ) ? {az_q[8], az_q} : el_q;
    ent_ang  = {{(ANG_W - 18){ent[9]}}, ent, 8'b0};
    hit      = rd_valid && (ent_ang > srch_needle);
    s_done   = hit || (rd_valid && rd_idx == srch_n - 1'b1);
    u        = hit ? rd_idx : srch_n;
    s_hi     = (u < srch_n - 1'b1) ? u : srch_n - 1'b1;
    s_lo     = (u != '0) ? u - 1'b1 : '0;
    // With no entry above the needle both bracket ends sit on the last entry.
    s_lo_ang = (hit && u != '0) ? prev_ang : ent_ang;
  end

  // Query operands.
  logic signed [ANG_W-1:0] q_phi;
  logic signed [ANG_W-1:0] q_theta;
  logic                    q_zpos;
  logic                    q_near;

  // Azimuth bracket with mirroring and swap, worked out on the search's last cycle.
  logic [CNTW-1:0]         rmin;
  logic [CNTW-1:0]         rmax;
  logic signed [ANG_W-1:0] amin;
  logic signed [ANG_W-1:0] amax;
  logic signed [ANG_W-1:0] thmin;
  logic signed [ANG_W-1:0] thmax;
  logic [CNTW-1:0]         c_rmin;
  logic [CNTW-1:0]         c_rmax;
  logic signed [ANG_W-1:0] c_amin;
  logic signed [ANG_W-1:0] c_amax;
  logic signed [ANG_W-1:0] c_thmin;
  logic signed [ANG_W-1:0] c_thmax;
  logic signed [SW-1:0]    d_lo;
  logic signed [SW-1:0]    d_hi;
  logic                    near_lo;

  always_comb begin
    c_rmin  = s_lo;
    c_rmax  = s_hi;
    c_amin  = s_lo_ang;
    c_amax  = ent_ang;
    c_thmin = q_theta;
    c_thmax = q_theta;
    if (s_lo == '0 && s_hi == '0) begin
      c_amin  = MIRROR_AZ_LOW2 - s_lo_ang;
      c_thmin = MIRROR_EL2 - q_theta;
    end
    if (s_lo == na - 1'b1 && s_hi == na - 1'b1) begin
      c_amax  = MIRROR_AZ_HIGH2 - ent_ang;
      c_thmax = MIRROR_EL2 - q_theta;
    end
    if (q_zpos) begin
      {c_amin, c_amax}   = {c_amax, c_amin};
      {c_rmin, c_rmax}   = {c_rmax, c_rmin};
      {c_thmin, c_thmax} = {c_thmax, c_thmin};
    end
    // Nearest pick between the two bracket entries; a tie keeps the lower one.
    d_lo = SW'(srch_needle) - SW'(s_lo_ang);
    d_hi = SW'(srch_needle) - SW'(ent_ang);
    if (d_lo < 0) d_lo = -d_lo;
    if (d_hi < 0) d_hi = -d_hi;
    near_lo = (d_lo <= d_hi);
  end

  // Elevation brackets.
  logic [CNTW-1:0]         a0;
  logic [CNTW-1:0]         a1;
  logic [CNTW-1:0]         b0;
  logic [CNTW-1:0]         b1;
  logic signed [ANG_W-1:0] a0_ang;
  logic signed [ANG_W-1:0] a1_ang;
  logic signed [ANG_W-1:0] b0_ang;
  logic signed [ANG_W-1:0] b1_ang;

  // Linear weights through one restoring divider.
  logic [1:0]              div_sel;
  logic                    div_busy;
  logic [NW-1:0]           div_r;
  logic [F:0]              div_lo;
  logic [F:0]              div_q;
  logic [NW-1:0]           div_den;
  logic [DCW-1:0]          div_cnt;
  logic [WW-1:0]           wl [3];
  logic signed [ANG_W-1:0] lx;
  logic signed [ANG_W-1:0] llo;
  logic signed [ANG_W-1:0] lhi;
  logic signed [SW-1:0]    lnum;
  logic signed [SW-1:0]    lden;
  logic [DVW-1:0]          dvd;
  logic [NW:0]             dtry;
  logic                    dge;

  always_comb begin
    case (div_sel)
      2'd0: begin
        lx = q_phi; llo = amin; lhi = amax;
      end
      2'd1: begin
        lx = thmin; llo = a0_ang; lhi = a1_ang;
      end
      default: begin
        lx = thmax; llo = b0_ang; lhi = b1_ang;
      end
    endcase
    lnum = SW'(lhi) - SW'(lx);
    lden = SW'(lhi) - SW'(llo);
    if (lden < 0) begin
      lden = -lden;
      lnum = -lnum;
    end
    dvd  = {NW'(lnum), {F{1'b0}}} + DVW'(NW'(lden) >> 1);
    dtry = {div_r, div_lo[F]};
    dge  = (dtry >= {1'b0, div_den});
  end

  // Shared multiplier: four weight products, then four index products, or one index for a nearest query.
  logic [2:0]       mul_step;
  logic             mul_ph;
  logic [WW-1:0]    mop_a;
  logic [WW-1:0]    mop_b;
  logic [CNTW-1:0]  madd;
  logic [PW-1:0]    prod;
  logic [PW-1:0]    prnd;
  logic [11:0]      res_idx [4];
  logic [16:0]      res_wt [4];

  always_comb begin
    madd = a0;
    case (mul_step)
      3'd0: begin
        mop_a = wl[0];         mop_b = wl[1];
      end
      3'd1: begin
        mop_a = wl[0];         mop_b = W_ONE - wl[1];
      end
      3'd2: begin
        mop_a = W_ONE - wl[0]; mop_b = wl[2];
      end
      3'd3: begin
        mop_a = W_ONE - wl[0]; mop_b = W_ONE - wl[2];
      end
      3'd4: begin
        mop_a = WW'(rmin);     mop_b = WW'(ne);
      end
      3'd5: begin
        mop_a = WW'(rmin);     mop_b = WW'(ne); madd = a1;
      end
      3'd6: begin
        mop_a = WW'(rmax);     mop_b = WW'(ne); madd = b0;
      end
      default: begin
        mop_a = WW'(rmax);     mop_b = WW'(ne); madd = b1;
      end
    endcase
    prnd = (prod + HALF) >> SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      num_azimuths   <= 7'd1;
      num_elevations <= 7'd1;
      out_valid      <= 1'b0;
      rd_valid       <= 1'b0;
      div_busy       <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'(REG_NUM_AZIMUTHS)) num_azimuths <= cfg_data;
        else num_elevations <= cfg_data;
      end
      // A result leaving in the same cycle as the next one is loaded is handled below.
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_acc && (cmd == CMD_BILINEAR || cmd == CMD_NEAREST)) begin
            q_phi       <= ANG_W'(azimuth_deg);
            q_theta     <= ANG_W'(elevation_deg);
            q_zpos      <= z_positive;
            q_near      <= (cmd == CMD_NEAREST);
            srch_needle <= ANG_W'(azimuth_deg);
            srch_n      <= na;
            scan        <= '0;
            rd_valid    <= 1'b0;
            state       <= S_AZ;
          end
        end
        S_AZ, S_EL_A, S_EL_B: begin
          if (!s_done) begin
            scan     <= scan + 1'b1;
            rd_valid <= (scan < srch_n);
            rd_idx   <= scan;
            if (rd_valid) prev_ang <= ent_ang;
          end else begin
            scan     <= '0;
            rd_valid <= 1'b0;
            srch_n   <= ne;
            if (state == S_AZ) begin
              if (q_near) begin
                rmin     <= near_lo ? s_lo : s_hi;
                srch_row <= near_lo ? s_lo : s_hi;
                srch_needle <= q_theta;
              end else begin
                rmin     <= c_rmin;
                rmax     <= c_rmax;
                amin     <= c_amin;
                amax     <= c_amax;
                thmin    <= c_thmin;
                thmax    <= c_thmax;
                srch_row <= c_rmin;
                srch_needle <= c_thmin;
              end
              state <= S_EL_A;
            end else if (state == S_EL_A) begin
              a0     <= (q_near && !near_lo) ? s_hi : s_lo;
              a1     <= s_hi;
              a0_ang <= s_lo_ang;
              a1_ang <= ent_ang;
              if (q_near) begin
                mul_step <= 3'd4;
                mul_ph   <= 1'b0;
                state    <= S_MUL;
              end else begin
                srch_row    <= rmax;
                srch_needle <= thmax;
                state       <= S_EL_B;
              end
            end else begin
              b0       <= s_lo;
              b1       <= s_hi;
              b0_ang   <= s_lo_ang;
              b1_ang   <= ent_ang;
              div_sel  <= 2'd0;
              div_busy <= 1'b0;
              state    <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            if (lden == '0 || lnum <= 0 || lnum >= lden) begin
              wl[div_sel] <= (lden != '0 && lnum >= lden && lnum > 0) ? W_ONE : '0;
              div_sel     <= div_sel + 1'b1;
              if (div_sel == 2'd2) begin
                mul_step <= 3'd0;
                mul_ph   <= 1'b0;
                state    <= S_MUL;
              end
            end else begin
              div_r    <= dvd[DVW-1:F+1];
              div_lo   <= dvd[F:0];
              div_den  <= NW'(lden);
              div_cnt  <= DCW'(WW);
              div_busy <= 1'b1;
            end
          end else begin
            div_r   <= dge ? NW'(dtry - {1'b0, div_den}) : NW'(dtry);
            div_lo  <= div_lo << 1;
            div_q   <= {div_q[F-1:0], dge};
            div_cnt <= div_cnt - 1'b1;
            if (div_cnt == DCW'(1)) begin
              wl[div_sel] <= {div_q[F-1:0], dge};
              div_busy    <= 1'b0;
              div_sel     <= div_sel + 1'b1;
              if (div_sel == 2'd2) begin
                mul_step <= 3'd0;
                mul_ph   <= 1'b0;
                state    <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          mul_ph <= !mul_ph;
          if (!mul_ph) begin
            prod <= mop_a * mop_b;
          end else begin
            if (mul_step[2]) res_idx[mul_step[1:0]] <= prod[11:0] + 12'(madd);
            else res_wt[mul_step[1:0]] <= prnd[16:0];
            mul_step <= mul_step + 1'b1;
            if (q_near) begin
              res_wt[0]  <= OUT_ONE;
              res_wt[1]  <= '0;
              res_wt[2]  <= '0;
              res_wt[3]  <= '0;
              res_idx[1] <= '0;
              res_idx[2] <= '0;
              res_idx[3] <= '0;
              state      <= S_DONE;
            end else if (mul_step == 3'd7) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            index_a   <= res_idx[0];
            index_b   <= res_idx[1];
            index_c   <= res_idx[2];
            index_d   <= res_idx[3];
            weight_a  <= res_wt[0];
            weight_b  <= res_wt[1];
            weight_c  <= res_wt[2];
            weight_d  <= res_wt[3];
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import hrir_bwl_pkg::*;

  // One command transaction on the input channel, with its fields at port widths.
  typedef struct {
    cmd_t               cmd;
    logic [5:0]         ring;
    logic [5:0]         slot;
    logic signed [9:0]  tdeg;
    logic signed [15:0] az;
    logic signed [17:0] el;
    logic               zp;
  } lookup_cmd_t;

  // One result transaction: four measurement indices and four Q1.16 weights.
  typedef struct packed {
    logic [3:0][11:0] idx;
    logic [3:0][16:0] wt;
  } lookup_res_t;

  // A row of the directed table. Where typed is set, want holds the result read straight
  // off the behaviour; otherwise the predictor supplies it.
  typedef struct {
    lookup_cmd_t it;
    bit          typed;
    lookup_res_t want;
  } dir_row_t;

  localparam longint WONE = 64'd65536;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [6:0]        cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        cmd = '0;
  logic [5:0]        ring = '0;
  logic [5:0]        slot = '0;
  logic signed [9:0] table_degrees = '0;
  logic signed [15:0] azimuth_deg = '0;
  logic signed [17:0] elevation_deg = '0;
  logic              z_positive = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [11:0]       index_a, index_b, index_c, index_d;
  logic [16:0]       weight_a, weight_b, weight_c, weight_d;

  hrir_bilinear_weight_lookup_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .ring(ring), .slot(slot), .table_degrees(table_degrees),
    .azimuth_deg(azimuth_deg), .elevation_deg(elevation_deg), .z_positive(z_positive),
    .out_valid(out_valid), .out_stall(out_stall),
    .index_a(index_a), .index_b(index_b), .index_c(index_c), .index_d(index_d),
    .weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c), .weight_d(weight_d)
  );

  always #6 clk = ~clk;

  // Our own copy of the grid tables and of the two count registers.
  int          az_tab [64];
  int          el_tab [4096];
  logic [6:0]  az_count_reg = 7'd1;
  logic [6:0]  el_count_reg = 7'd1;

  lookup_res_t pending_lookups [$];
  int          mismatches = 0;
  int          accepted_items = 0;
  int          results_seen = 0;
  longint      cycles = 0;
  bit          calm = 1'b0;

  function automatic int unsigned eff_count(logic [6:0] v);
    if (v == 0) return 1;
    return (v > 64) ? 64 : int'(v);
  endfunction

  function automatic longint grid_entry(bit is_az, int unsigned base, int unsigned k);
    return is_az ? longint'(az_tab[k]) * 256 : longint'(el_tab[base + k]) * 256;
  endfunction

  // Upper-bound search: first position whose entry exceeds the needle, then clipped
  // into a bracketing pair of positions.
  function automatic void bracket(bit is_az, int unsigned base, int unsigned n,
                                  longint needle, output int unsigned lo,
                                  output int unsigned hi);
    int unsigned u;
    u = n;
    for (int unsigned i = 0; i < n; i++) begin
      if (grid_entry(is_az, base, i) > needle) begin
        u = i;
        break;
      end
    end
    hi = (u < n - 1) ? u : n - 1;
    lo = (u > 0) ? u - 1 : 0;
  endfunction

  function automatic void lin_weights(longint x, longint lo, longint hi,
                                      output longint wlo, output longint whi);
    longint num, den, w;
    num = hi - x;
    den = hi - lo;
    if (den == 0) begin
      wlo = 0;
      whi = WONE;
      return;
    end
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num <= 0) w = 0;
    else if (num >= den) w = WONE;
    else w = ((num << 16) + den / 2) / den;
    wlo = w;
    whi = WONE - w;
  endfunction

  function automatic logic [16:0] weight_product(longint a, longint b);
    return 17'((a * b + 32768) >> 16);
  endfunction

  function automatic logic [11:0] meas_index(int unsigned r, int unsigned s,
                                             int unsigned ne);
    return 12'(r * ne + s);
  endfunction

  function automatic longint abs_gap(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Applies one command to the shadow tables; returns 1 with the expected result for a query.
  function automatic bit predict_lookup(lookup_cmd_t it, output lookup_res_t res);
    int unsigned na, ne, r0, r1, a0, a1, b0, b1, tmp;
    longint phi, theta, amin, amax, th_min, th_max, t;
    longint wp0, wp1, wa0, wa1, wb0, wb1;
    na = eff_count(az_count_reg);
    ne = eff_count(el_count_reg);
    phi = longint'(it.az);
    theta = longint'(it.el);
    res = '0;
    case (it.cmd)
      CMD_LOAD_AZ: begin
        az_tab[it.ring] = int'($signed(it.tdeg[8:0]));
        return 1'b0;
      end
      CMD_LOAD_EL: begin
        el_tab[it.ring * 64 + it.slot] = int'(it.tdeg);
        return 1'b0;
      end
      CMD_NEAREST: begin
        bracket(1'b1, 0, na, phi, r0, r1);
        tmp = (abs_gap(phi, grid_entry(1'b1, 0, r0)) <= abs_gap(phi, grid_entry(1'b1, 0, r1)))
              ? r0 : r1;
        bracket(1'b0, tmp * 64, ne, theta, a0, a1);
        a0 = (abs_gap(theta, grid_entry(1'b0, tmp * 64, a0)) <=
              abs_gap(theta, grid_entry(1'b0, tmp * 64, a1))) ? a0 : a1;
        res.idx[0] = meas_index(tmp, a0, ne);
        res.wt[0] = OUT_ONE;
        return 1'b1;
      end
      default: begin
        bracket(1'b1, 0, na, phi, r0, r1);
        amin = grid_entry(1'b1, 0, r0);
        amax = grid_entry(1'b1, 0, r1);
        th_min = theta;
        th_max = theta;
        // Mirror past the first and the last ring.
        if (r0 == 0 && r1 == 0) begin
          amin = longint'(MIRROR_AZ_LOW2) - amin;
          th_min = longint'(MIRROR_EL2) - th_min;
        end
        if (r0 == na - 1 && r1 == na - 1) begin
          amax = longint'(MIRROR_AZ_HIGH2) - amax;
          th_max = longint'(MIRROR_EL2) - th_max;
        end
        if (it.zp) begin
          t = amin; amin = amax; amax = t;
          tmp = r0; r0 = r1; r1 = tmp;
          t = th_min; th_min = th_max; th_max = t;
        end
        bracket(1'b0, r0 * 64, ne, th_min, a0, a1);
        bracket(1'b0, r1 * 64, ne, th_max, b0, b1);
        lin_weights(phi, amin, amax, wp0, wp1);
        lin_weights(th_min, grid_entry(1'b0, r0 * 64, a0), grid_entry(1'b0, r0 * 64, a1),
                    wa0, wa1);
        lin_weights(th_max, grid_entry(1'b0, r1 * 64, b0), grid_entry(1'b0, r1 * 64, b1),
                    wb0, wb1);
        res.idx[0] = meas_index(r0, a0, ne);
        res.idx[1] = meas_index(r0, a1, ne);
        res.idx[2] = meas_index(r1, b0, ne);
        res.idx[3] = meas_index(r1, b1, ne);
        res.wt[0] = weight_product(wp0, wa0);
        res.wt[1] = weight_product(wp0, wa1);
        res.wt[2] = weight_product(wp1, wb0);
        res.wt[3] = weight_product(wp1, wb1);
        return 1'b1;
      end
    endcase
  endfunction

  // Offers one transaction, with random idle cycles in front of it unless the calm
  // stretch is running, and records the expectation once it has been accepted.
  task automatic send_item(lookup_cmd_t it, bit typed, lookup_res_t want);
    lookup_res_t got;
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= it.cmd;
    ring          <= it.ring;
    slot          <= it.slot;
    table_degrees <= it.tdeg;
    azimuth_deg   <= it.az;
    elevation_deg <= it.el;
    z_positive    <= it.zp;
    do @(posedge clk); while (in_stall);
    accepted_items++;
    calm = (accepted_items >= 700 && accepted_items < 1000);
    if (predict_lookup(it, got)) pending_lookups.push_back(typed ? want : got);
  endtask

  task automatic send(lookup_cmd_t it);
    send_item(it, 1'b0, '0);
  endtask

  function automatic lookup_cmd_t make_cmd(cmd_t c, int r, int s, int td, int a, int e, bit z);
    lookup_cmd_t it;
    it.cmd = c;
    it.ring = 6'(r);
    it.slot = 6'(s);
    it.tdeg = 10'(td);
    it.az = 16'(a);
    it.el = 18'(e);
    it.zp = z;
    return it;
  endfunction

  function automatic dir_row_t make_row(lookup_cmd_t it, bit typed, int w0, int w1, int w2,
                                        int w3);
    dir_row_t row;
    row.it = it;
    row.typed = typed;
    row.want = '0;
    row.want.wt[0] = 17'(w0);
    row.want.wt[1] = 17'(w1);
    row.want.wt[2] = 17'(w2);
    row.want.wt[3] = 17'(w3);
    return row;
  endfunction

  // The counts are only changed once every result is in and the block has settled.
  task automatic set_counts(int na_val, int ne_val);
    while (pending_lookups.size() != 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b0;
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= 1'(REG_NUM_AZIMUTHS);
    cfg_data  <= 7'(na_val);
    @(posedge clk);
    cfg_index <= 1'(REG_NUM_ELEVATIONS);
    cfg_data  <= 7'(ne_val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    az_count_reg = 7'(na_val);
    el_count_reg = 7'(ne_val);
  endtask

  // Writes every entry that a query under the current counts can read. Mostly sorted
  // ascending with random steps (repeats included); now and then scrambled.
  task automatic fill_tables(bit scrambled);
    int unsigned na, ne;
    int v, step;
    na = eff_count(az_count_reg);
    ne = eff_count(el_count_reg);
    step = 180 / int'(na);
    v = -90 - int'($urandom_range(0, 30));
    for (int r = 0; r < int'(na); r++) begin
      send(make_cmd(CMD_LOAD_AZ, r, 0, scrambled ? int'($urandom_range(0, 720)) - 360 : v,
                    0, 0, 0));
      v += int'($urandom_range(0, step + 1));
    end
    step = 360 / int'(ne);
    for (int r = 0; r < int'(na); r++) begin
      v = -100 + int'($urandom_range(0, 20));
      for (int s = 0; s < int'(ne); s++) begin
        send(make_cmd(CMD_LOAD_EL, r, s, scrambled ? int'($urandom_range(0, 720)) - 360 : v,
                      0, 0, 0));
        v += int'($urandom_range(0, step));
        if (v > 360) v = 360;
      end
    end
  endtask

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // A random query, mostly aimed close to grid points so that brackets and mirrors are hit.
  function automatic lookup_cmd_t random_query();
    int unsigned na, ne, k, s;
    int a, e;
    na = eff_count(az_count_reg);
    ne = eff_count(el_count_reg);
    k = $urandom_range(0, na - 1);
    s = $urandom_range(0, ne - 1);
    if ($urandom_range(0, 3) == 0) begin
      a = int'($urandom_range(0, 46080)) - 23040;
      e = int'($urandom_range(0, 92160)) - 23040;
    end else begin
      a = az_tab[k] * 256 + int'($urandom_range(0, 2400)) - 1200;
      e = el_tab[k * 64 + s] * 256 + int'($urandom_range(0, 2400)) - 1200;
      if ($urandom_range(0, 7) == 0) a = az_tab[k] * 256;
      if ($urandom_range(0, 7) == 0) e = el_tab[k * 64 + s] * 256;
    end
    return make_cmd(($urandom_range(0, 2) == 0) ? CMD_NEAREST : CMD_BILINEAR,
                    $urandom_range(0, 63), $urandom_range(0, 63),
                    int'($urandom_range(0, 1023)) - 512,
                    clip(a, -23040, 23040), clip(e, -23040, 69120), $urandom_range(0, 1));
  endfunction

  // Receiver: random stalls, one long hold-off, and the comparison against the oldest
  // expectation for every result transaction that is taken.
  int hold_cycles = 0;
  bit held_once = 1'b0;

  always @(posedge clk) begin
    lookup_res_t exp_res, act;
    if (!rst && out_valid && !out_stall) begin
      act.idx = {index_d, index_c, index_b, index_a};
      act.wt = {weight_d, weight_c, weight_b, weight_a};
      results_seen++;
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %p", act);
      end else begin
        exp_res = pending_lookups.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (act.idx[i] !== exp_res.idx[i] || act.wt[i] !== exp_res.wt[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result %0d lane %0d: expected index %0d weight %0d, got index %0d weight %0d",
                       results_seen, i, exp_res.idx[i], exp_res.wt[i], act.idx[i], act.wt[i]);
          end
        end
      end
    end
    // Once enough traffic has gone through, the receiver holds off long enough for
    // the output register and the sequencer to fill and the input to stall.
    if (!held_once && results_seen == 300) begin
      held_once = 1'b1;
      hold_cycles = 3000;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 11);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  dir_row_t dir_rows [$];

  initial begin
    int extremes [8][2];
    int na_val, ne_val, nq;

    for (int i = 0; i < 64; i++) az_tab[i] = 0;
    for (int i = 0; i < 4096; i++) el_tab[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with the counts still at their reset value of one. With a single
    // ring and a single elevation every index is zero, the nearest query has full weight
    // and the mirrored bilinear query splits the weight in half.
    dir_rows.push_back(make_row(make_cmd(CMD_LOAD_AZ, 0, 0, 0, 0, 0, 0), 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(make_cmd(CMD_LOAD_EL, 0, 0, 0, 0, 0, 0), 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(make_cmd(CMD_NEAREST, 0, 0, 0, 0, 0, 0), 1'b1, 65536, 0, 0, 0));
    dir_rows.push_back(make_row(make_cmd(CMD_BILINEAR, 0, 0, 0, 0, 0, 0), 1'b1,
                                0, 32768, 0, 32768));
    dir_rows.push_back(make_row(make_cmd(CMD_BILINEAR, 0, 0, 0, 0, 0, 1), 1'b1,
                                0, 32768, 0, 32768));
    // Azimuth load with a value wider than the table keeps only the low nine bits.
    dir_rows.push_back(make_row(make_cmd(CMD_LOAD_AZ, 0, 0, 300, 0, 0, 0), 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(make_cmd(CMD_BILINEAR, 0, 0, 0, 23040, 69120, 0), 1'b0,
                                0, 0, 0, 0));
    dir_rows.push_back(make_row(make_cmd(CMD_BILINEAR, 0, 0, 0, -23040, -23040, 1), 1'b0,
                                0, 0, 0, 0));
    dir_rows.push_back(make_row(make_cmd(CMD_LOAD_EL, 0, 0, -360, 0, 0, 0), 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(make_cmd(CMD_NEAREST, 0, 0, 0, 23040, -23040, 1), 1'b1,
                                65536, 0, 0, 0));
    dir_rows.push_back(make_row(make_cmd(CMD_LOAD_EL, 63, 63, 360, 0, 0, 0), 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(make_cmd(CMD_LOAD_AZ, 63, 0, -360, 0, 0, 0), 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(make_cmd(CMD_LOAD_AZ, 0, 0, 511, 0, 0, 0), 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(make_cmd(CMD_BILINEAR, 0, 0, 0, 255, 69120, 1), 1'b0,
                                0, 0, 0, 0));
    dir_rows.push_back(make_row(make_cmd(CMD_NEAREST, 0, 0, 0, -23040, 69120, 0), 1'b1,
                                65536, 0, 0, 0));
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    // Extreme count settings first: zero acts as one, values above the table depth
    // act as the depth. Then random small grids fill the rest of the run.
    extremes = '{'{0, 0}, '{127, 1}, '{1, 127}, '{64, 3}, '{2, 64}, '{64, 1}, '{1, 64},
                 '{0, 5}};
    for (int ph = 0; accepted_items < 1700; ph++) begin
      if (ph < 8) begin
        na_val = extremes[ph][0];
        ne_val = extremes[ph][1];
      end else begin
        na_val = $urandom_range(1, 8);
        ne_val = $urandom_range(1, 8);
      end
      set_counts(na_val, ne_val);
      fill_tables($urandom_range(0, 9) == 0);
      nq = $urandom_range(20, 60);
      for (int q = 0; q < nq; q++) begin
        // A few random loads land between the queries; they may reorder a table.
        if ($urandom_range(0, 9) == 0)
          send(make_cmd(($urandom_range(0, 1) == 0) ? CMD_LOAD_AZ : CMD_LOAD_EL,
                        $urandom_range(0, 63), $urandom_range(0, 63),
                        int'($urandom_range(0, 720)) - 360, 0, 0, 0));
        else
          send(random_query());
      end
    end
    in_valid <= 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (pending_lookups.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
